/* hw/rtl/ray_sphere_closest_hit_top_macros.svh */
// Assertion helpers used by the top-level RTL.
`ifndef RAY_SPHERE_CLOSEST_HIT_TOP_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define RSCH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define RSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rsch_pkg.sv */
`timescale 1ns / 1ps
package rsch_pkg;
  localparam int FieldW   = 48;
  localparam int RadiusW  = 15;
  localparam int OutW     = 16;
  localparam int WideW    = 64;
  localparam int QuotW    = 31;
  localparam int DivLat   = QuotW + 1;
  localparam int SetupLat = 6;
endpackage

/* hw/rtl/rsch_delay.sv */
`timescale 1ns / 1ps
module rsch_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);
  logic [W-1:0] line_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < D; j++) begin
        line_q[j] <= '0;
      end
    end else if (en_i) begin
      line_q[0] <= d_i;
      for (int j = 1; j < D; j++) begin
        line_q[j] <= line_q[j-1];
      end
    end
  end

  assign d_o = line_q[D-1];
endmodule

/* hw/rtl/rsch_setup.sv */
`timescale 1ns / 1ps
module rsch_setup #(
  parameter int CW  = 16,
  parameter int AW  = 32,
  parameter int BW  = 34,
  parameter int VVW = 34,
  parameter int KW  = 35,
  parameter int B2W = 66,
  parameter int AKW = 66,
  parameter int QW0 = 67,
  parameter int QE  = 68
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rsch_pkg::FieldW-1:0]   ray_origin_i,
  input  logic [rsch_pkg::FieldW-1:0]   ray_dir_i,
  input  logic [rsch_pkg::FieldW-1:0]   sphere_center_i,
  input  logic [rsch_pkg::RadiusW-1:0]  sphere_radius_i,
  input  logic [rsch_pkg::FieldW-1:0]   ref_point_i,
  output logic                          valid_o,
  output logic                          ok_o,
  output logic [QE-1:0]                 q_o,
  output logic [AW-1:0]                 a_o,
  output logic signed [BW-1:0]          bdot_o,
  output logic [3*CW-1:0]               o_o,
  output logic [3*CW-1:0]               d_o,
  output logic [3*CW-1:0]               f_o
);
  import rsch_pkg::*;

  localparam int VW  = CW + 1;
  localparam int SBW = 9 * CW;
  localparam int RRW = 2 * RadiusW;

  function automatic logic [3*CW-1:0] unpack3(input logic [FieldW-1:0] p);
    logic [WideW-1:0] w;
    w = WideW'(p);
    return w[3*CW-1:0];
  endfunction

  logic [SetupLat-1:0] vld_q;
  logic [SBW-1:0]      sb_q [SetupLat];
  logic [3*CW-1:0]     org_in, ctr_in;

  logic signed [VW-1:0]      v1_q [3];
  logic [RadiusW-1:0]        r1_q;
  logic [AW-1:0]             dd2_q [3];
  logic signed [VW+CW-1:0]   vd2_q [3];
  logic signed [2*VW-1:0]    vv2_q [3];
  logic [RRW-1:0]            rr2_q, rr3_q;
  logic [AW-1:0]             a3_q, a4_q, a5_q;
  logic signed [BW-1:0]      b3_q, b4_q, b5_q, b6_q;
  logic [VVW-1:0]            vv3_q;
  logic signed [KW-1:0]      k4_q;
  logic [B2W-1:0]            b2_5_q;
  logic signed [AKW:0]       ak5_q;
  logic [AW-1:0]             a6_q;
  logic [QE-1:0]             q6_q;
  logic                      ok6_q;

  logic signed [2*BW-1:0]    bsq;
  logic signed [AW+KW:0]     akf;
  logic signed [QW0:0]       qs;

  assign org_in = unpack3(ray_origin_i);
  assign ctr_in = unpack3(sphere_center_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SetupLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= {unpack3(ref_point_i), unpack3(ray_dir_i), org_in};
      for (int j = 1; j < SetupLat; j++) begin
        sb_q[j] <= sb_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v1_q[i] <= VW'($signed(org_in[i*CW +: CW])) - VW'($signed(ctr_in[i*CW +: CW]));
      end
      r1_q <= sphere_radius_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= AW'($signed(sb_q[0][CW*3+i*CW +: CW]) * $signed(sb_q[0][CW*3+i*CW +: CW]));
        vd2_q[i] <= v1_q[i] * $signed(sb_q[0][CW*3+i*CW +: CW]);
        vv2_q[i] <= v1_q[i] * v1_q[i];
      end
      rr2_q <= r1_q * r1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q  <= dd2_q[0] + dd2_q[1] + dd2_q[2];
      b3_q  <= BW'(vd2_q[0]) + BW'(vd2_q[1]) + BW'(vd2_q[2]);
      vv3_q <= VVW'(vv2_q[0]) + VVW'(vv2_q[1]) + VVW'(vv2_q[2]);
      rr3_q <= rr2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k4_q <= KW'($signed({1'b0, vv3_q})) - KW'($signed({1'b0, rr3_q}));
      a4_q <= a3_q;
      b4_q <= b3_q;
    end
  end

  assign bsq = b4_q * b4_q;
  assign akf = $signed({1'b0, a4_q}) * k4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_5_q <= bsq[B2W-1:0];
      ak5_q  <= akf[AKW:0];
      a5_q   <= a4_q;
      b5_q   <= b4_q;
    end
  end

  assign qs = (QW0+1)'($signed({1'b0, b2_5_q})) - (QW0+1)'(ak5_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q6_q  <= QE'(qs[QW0-1:0]);
      ok6_q <= (a5_q != '0) && !qs[QW0];
      a6_q  <= a5_q;
      b6_q  <= b5_q;
    end
  end

  assign valid_o = vld_q[SetupLat-1];
  assign ok_o    = ok6_q;
  assign q_o     = q6_q;
  assign a_o     = a6_q;
  assign bdot_o  = b6_q;
  assign o_o     = sb_q[SetupLat-1][0 +: 3*CW];
  assign d_o     = sb_q[SetupLat-1][3*CW +: 3*CW];
  assign f_o     = sb_q[SetupLat-1][6*CW +: 3*CW];
endmodule

/* hw/rtl/rsch_isqrt.sv */
`timescale 1ns / 1ps
module rsch_isqrt #(
  parameter int QE = 68,
  parameter int SW = 34
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QE-1:0] q_i,
  output logic [SW-1:0] root_o
);
  logic [SW+1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [QE-1:0] rest_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_st
    logic [SW+1:0] rem_s;
    logic [SW-1:0] root_s;
    logic [QE-1:0] rest_s;
    logic [SW+3:0] t, trial;
    if (j == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign rest_s = q_i;
    end else begin : g_next
      assign rem_s  = rem_q[j-1];
      assign root_s = root_q[j-1];
      assign rest_s = rest_q[j-1];
    end
    assign t     = {rem_s, rest_s[QE-1 -: 2]};
    assign trial = {2'b00, root_s, 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t >= trial) begin
          rem_q[j]  <= (SW+2)'(t - trial);
          root_q[j] <= {root_s[SW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= t[SW+1:0];
          root_q[j] <= {root_s[SW-2:0], 1'b0};
        end
        rest_q[j] <= {rest_s[QE-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SW-1];
endmodule

/* hw/rtl/rsch_div.sv */
`timescale 1ns / 1ps
module rsch_div #(
  parameter int NUMW = 53,
  parameter int DENW = 33
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [NUMW-1:0]             num_i,
  input  logic [DENW-1:0]             den_i,
  output logic [rsch_pkg::QuotW-1:0]  off_o
);
  import rsch_pkg::*;

  localparam int XW = ((NUMW > DENW + QuotW) ? NUMW : DENW + QuotW) + 1;
  localparam logic [QuotW-1:0] Cap = {1'b1, {(QuotW-1){1'b0}}};

  logic [XW-1:0]    rem_q [DivLat];
  logic [DENW-1:0]  den_q [DivLat];
  logic [QuotW-1:0] quo_q [DivLat];
  logic             cap_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= XW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      cap_q[0] <= XW'(num_i) >= (XW'(den_i) << QuotW);
    end
  end

  for (genvar k = 1; k < DivLat; k++) begin : g_st
    localparam int Bit = QuotW - k;
    logic [XW-1:0] sh;
    logic          fit;
    assign sh  = XW'(den_q[k-1]) << Bit;
    assign fit = rem_q[k-1] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fit ? rem_q[k-1] - sh : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        cap_q[k] <= cap_q[k-1];
        quo_q[k] <= quo_q[k-1] | (fit ? (QuotW'(1) << Bit) : '0);
      end
    end
  end

  assign off_o = (cap_q[DivLat-1] || quo_q[DivLat-1] > Cap) ? Cap : quo_q[DivLat-1];
endmodule

/* hw/rtl/ray_sphere_closest_hit_top.sv */
// One transfer per cycle when not stalled; SW square-root stages, SW = half the even-rounded
// discriminant width (34 at 16-bit coords), and six 32-stage dividers.
// An output stall while out_valid_o is high freezes the whole pipeline and holds in_stall_o.
// Reset: rst_ni asynchronous, active low, clears every valid bit; no result after reset.
`timescale 1ns / 1ps
`include "ray_sphere_closest_hit_top_macros.svh"
module ray_sphere_closest_hit_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rsch_pkg::FieldW-1:0]        ray_origin_i,
  input  logic [rsch_pkg::FieldW-1:0]        ray_dir_i,
  input  logic [rsch_pkg::FieldW-1:0]        sphere_center_i,
  input  logic [rsch_pkg::RadiusW-1:0]       sphere_radius_i,
  input  logic [rsch_pkg::FieldW-1:0]        ref_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               hit_o,
  output logic signed [rsch_pkg::OutW-1:0]   hit_x_o,
  output logic signed [rsch_pkg::OutW-1:0]   hit_y_o,
  output logic signed [rsch_pkg::OutW-1:0]   hit_z_o
);
  import rsch_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = 2 * CW;
  localparam int BW   = 2 * CW + 2;
  localparam int VVW  = 2 * CW + 2;
  localparam int RRW  = 2 * RadiusW;
  localparam int KW   = ((VVW > RRW) ? VVW : RRW) + 1;
  localparam int B2W  = 2 * (BW - 1);
  localparam int AKW  = AW + KW - 1;
  localparam int QW0  = ((B2W > AKW) ? B2W : AKW) + 1;
  localparam int QE   = QW0 + (QW0 % 2);
  localparam int SW   = QE / 2;
  localparam int NW   = ((BW > SW + 1) ? BW : SW + 1) + 1;
  localparam int NMW  = NW - 1;
  localparam int PRW  = CW + NMW;
  localparam int NUMW = PRW + 2;
  localparam int DENW = AW + 1;
  localparam int PW   = ((CW > QuotW) ? CW : QuotW) + 2;
  localparam int SQW  = 2 * PW;
  localparam int DSW  = SQW + 2;
  localparam int SB1W = 2 + AW + BW + 9 * CW;
  localparam int SB2W = 2 + 6 * CW + 6;

  logic en;

  logic                 s_valid, s_ok;
  logic [QE-1:0]        s_q;
  logic [AW-1:0]        s_a;
  logic signed [BW-1:0] s_bdot;
  logic [3*CW-1:0]      s_o, s_d, s_f;

  logic [SB1W-1:0]      sb1_out;
  logic                 t_valid, t_ok;
  logic [AW-1:0]        t_a;
  logic signed [BW-1:0] t_bdot;
  logic [3*CW-1:0]      t_o, t_d, t_f;
  logic [SW-1:0]        t_root;

  logic                 n_vld_q, n_ok_q;
  logic [AW-1:0]        n_a_q;
  logic [3*CW-1:0]      n_o_q, n_d_q, n_f_q;
  logic signed [NW-1:0] n_val_q [2];
  logic signed [NW-1:0] nb, nr;

  logic                 m_vld_q, m_ok_q;
  logic [AW-1:0]        m_a_q;
  logic [3*CW-1:0]      m_o_q, m_f_q;
  logic [NMW-1:0]       m_nmag_q [2];
  logic [1:0]           m_nneg_q;
  logic [CW-1:0]        m_dmag_q [3];
  logic [2:0]           m_dneg_q;

  logic                 x_vld_q, x_ok_q;
  logic [AW-1:0]        x_a_q;
  logic [3*CW-1:0]      x_o_q, x_f_q;
  logic [PRW-1:0]       x_prod_q [6];
  logic [5:0]           x_neg_q;

  logic                 y_vld_q, y_ok_q;
  logic [3*CW-1:0]      y_o_q, y_f_q;
  logic [NUMW-1:0]      y_num_q [6];
  logic [DENW-1:0]      y_den_q;
  logic [5:0]           y_neg_q;

  logic [QuotW-1:0]     off [6];
  logic [SB2W-1:0]      sb2_out;
  logic                 u_valid, u_ok;
  logic [3*CW-1:0]      u_o, u_f;
  logic [5:0]           u_neg;

  logic                 p_vld_q, p_ok_q;
  logic [3*CW-1:0]      p_f_q;
  logic signed [PW-1:0] p_q [6];

  logic                 e_vld_q, e_ok_q;
  logic signed [PW-1:0] e_p_q [6];
  logic [PW-1:0]        e_mag_q [6];

  logic                 q_vld_q, q_ok_q;
  logic signed [PW-1:0] q_p_q [6];
  logic [SQW-1:0]       q_sq_q [6];

  logic                 d_vld_q, d_ok_q;
  logic signed [PW-1:0] d_p_q [6];
  logic [DSW-1:0]       d_dist_q [2];

  logic                 o_vld_q, o_hit_q;
  logic signed [OutW-1:0] o_pt_q [3];

  logic signed [PW-1:0] sat_hi, sat_lo;

  assign en         = !(o_vld_q && out_stall_i);
  assign in_stall_o = !en;

  rsch_setup #(
    .CW(CW), .AW(AW), .BW(BW), .VVW(VVW), .KW(KW),
    .B2W(B2W), .AKW(AKW), .QW0(QW0), .QE(QE)
  ) u_setup (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .ray_origin_i, .ray_dir_i, .sphere_center_i, .sphere_radius_i, .ref_point_i,
    .valid_o(s_valid), .ok_o(s_ok), .q_o(s_q), .a_o(s_a), .bdot_o(s_bdot),
    .o_o(s_o), .d_o(s_d), .f_o(s_f)
  );

  rsch_isqrt #(.QE(QE), .SW(SW)) u_isqrt (
    .clk_i, .en_i(en), .q_i(s_q), .root_o(t_root)
  );

  rsch_delay #(.W(SB1W), .D(SW)) u_sb1 (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({s_valid, s_ok, s_a, s_bdot, s_o, s_d, s_f}), .d_o(sb1_out)
  );
  assign {t_valid, t_ok, t_a, t_bdot, t_o, t_d, t_f} = sb1_out;

  assign nb = NW'(t_bdot);
  assign nr = NW'($signed({1'b0, t_root}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      x_vld_q <= 1'b0;
      y_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      n_vld_q <= t_valid;
      m_vld_q <= n_vld_q;
      x_vld_q <= m_vld_q;
      y_vld_q <= x_vld_q;
      p_vld_q <= u_valid;
      e_vld_q <= p_vld_q;
      q_vld_q <= e_vld_q;
      d_vld_q <= q_vld_q;
      o_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_ok_q     <= t_ok;
      n_a_q      <= t_a;
      n_o_q      <= t_o;
      n_d_q      <= t_d;
      n_f_q      <= t_f;
      n_val_q[0] <= nr - nb;
      n_val_q[1] <= -nb - nr;

      m_ok_q <= n_ok_q;
      m_a_q  <= n_a_q;
      m_o_q  <= n_o_q;
      m_f_q  <= n_f_q;
      for (int k = 0; k < 2; k++) begin
        m_nneg_q[k] <= n_val_q[k][NW-1];
        m_nmag_q[k] <= n_val_q[k][NW-1] ? NMW'(-n_val_q[k]) : NMW'(n_val_q[k]);
      end
      for (int i = 0; i < 3; i++) begin
        m_dneg_q[i] <= n_d_q[i*CW+CW-1];
        m_dmag_q[i] <= n_d_q[i*CW+CW-1] ? CW'(-$signed(n_d_q[i*CW +: CW]))
                                        : n_d_q[i*CW +: CW];
      end

      x_ok_q <= m_ok_q;
      x_a_q  <= m_a_q;
      x_o_q  <= m_o_q;
      x_f_q  <= m_f_q;
      for (int j = 0; j < 6; j++) begin
        x_prod_q[j] <= PRW'(m_dmag_q[j%3] * m_nmag_q[j/3]);
        x_neg_q[j]  <= m_dneg_q[j%3] ^ m_nneg_q[j/3];
      end

      y_ok_q  <= x_ok_q;
      y_o_q   <= x_o_q;
      y_f_q   <= x_f_q;
      y_neg_q <= x_neg_q;
      y_den_q <= {x_a_q, 1'b0};
      for (int j = 0; j < 6; j++) begin
        y_num_q[j] <= NUMW'({x_prod_q[j], 1'b0}) + NUMW'(x_a_q);
      end
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_div
    rsch_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
      .clk_i, .en_i(en), .num_i(y_num_q[j]), .den_i(y_den_q), .off_o(off[j])
    );
  end

  rsch_delay #(.W(SB2W), .D(DivLat)) u_sb2 (
    .clk_i, .rst_ni, .en_i(en),
    .d_i({y_vld_q, y_ok_q, y_o_q, y_f_q, y_neg_q}), .d_o(sb2_out)
  );
  assign {u_valid, u_ok, u_o, u_f, u_neg} = sb2_out;

  assign sat_hi = PW'({1'b0, {(CW-1){1'b1}}});
  assign sat_lo = ~sat_hi;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ok_q <= u_ok;
      p_f_q  <= u_f;
      for (int j = 0; j < 6; j++) begin
        p_q[j] <= u_neg[j]
          ? PW'($signed(u_o[(j%3)*CW +: CW])) - PW'($signed({1'b0, off[j]}))
          : PW'($signed(u_o[(j%3)*CW +: CW])) + PW'($signed({1'b0, off[j]}));
      end

      e_ok_q <= p_ok_q;
      for (int j = 0; j < 6; j++) begin
        logic signed [PW:0] diff;
        diff = (PW+1)'($signed(p_f_q[(j%3)*CW +: CW])) - (PW+1)'(p_q[j]);
        e_p_q[j]   <= p_q[j];
        e_mag_q[j] <= diff[PW] ? PW'(-diff) : PW'(diff);
      end

      q_ok_q <= e_ok_q;
      for (int j = 0; j < 6; j++) begin
        q_p_q[j]  <= e_p_q[j];
        q_sq_q[j] <= e_mag_q[j] * e_mag_q[j];
      end

      d_ok_q <= q_ok_q;
      d_p_q  <= q_p_q;
      for (int k = 0; k < 2; k++) begin
        d_dist_q[k] <= DSW'(q_sq_q[3*k]) + DSW'(q_sq_q[3*k+1]) + DSW'(q_sq_q[3*k+2]);
      end

      o_hit_q <= d_ok_q;
      for (int i = 0; i < 3; i++) begin
        logic signed [PW-1:0] pc;
        logic signed [CW-1:0] sv;
        pc = (d_dist_q[0] < d_dist_q[1]) ? d_p_q[i] : d_p_q[3+i];
        if (pc > sat_hi) begin
          sv = sat_hi[CW-1:0];
        end else if (pc < sat_lo) begin
          sv = sat_lo[CW-1:0];
        end else begin
          sv = pc[CW-1:0];
        end
        o_pt_q[i] <= d_ok_q ? OutW'(sv) : '0;
      end
    end
  end

  assign out_valid_o = o_vld_q;
  assign hit_o       = o_vld_q && o_hit_q;
  assign hit_x_o     = o_pt_q[0];
  assign hit_y_o     = o_pt_q[1];
  assign hit_z_o     = o_pt_q[2];

  `RSCH_ASSERT(a_nohit_zero, out_valid_o && !hit_o, hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0, "miss carries a nonzero point")
  `RSCH_ASSERT(a_idle_nohit, !out_valid_o, !hit_o, "hit without a result")
  `RSCH_ASSERT_NEXT(a_freeze, in_stall_o, $stable(n_vld_q) && $stable(p_vld_q) && $stable(o_vld_q), "pipeline advanced during stall")
endmodule
